### sv/qea_pkg.sv
// shared constants and types for the quadratic equation analyzer
package qea_pkg;

    localparam int COEF_BITS   = 16;
    localparam int FRAC_BITS   = 16;
    localparam int OUT_BITS    = 64;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CONC_UP   = 2'd0,
        CONC_DOWN = 2'd1,
        CONC_FLAT = 2'd2
    } conc_t;

    typedef enum logic [1:0] {
        ROOTS_NONE = 2'd0,
        ROOTS_ONE  = 2'd1,
        ROOTS_TWO  = 2'd2
    } count_t;

    typedef struct packed {
        conc_t  concavity;
        count_t root_count;
        logic   roots_valid;
    } class_t;

endpackage

### sv/qea_in_if.sv
// coefficient channel: valid, ready and one set of coefficients
interface qea_in_if #(
    parameter int COEF_BITS = qea_pkg::COEF_BITS
);
    logic                        valid;
    logic                        ready;
    logic signed [COEF_BITS-1:0] coef_a;
    logic signed [COEF_BITS-1:0] coef_b;
    logic signed [COEF_BITS-1:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

### sv/qea_out_if.sv
// result channel: valid, ready and one analysis result
interface qea_out_if #(
    parameter int COEF_BITS = qea_pkg::COEF_BITS
);
    localparam int DISC_BITS = 2 * COEF_BITS + 2;
    localparam int OB        = qea_pkg::OUT_BITS;

    logic                        valid;
    logic                        ready;
    logic signed [DISC_BITS-1:0] discriminant;
    logic [1:0]                  concavity;
    logic [1:0]                  root_count;
    logic signed [OB-1:0]        vertex_x;
    logic signed [OB-1:0]        vertex_y;
    logic signed [OB-1:0]        root_low;
    logic signed [OB-1:0]        root_high;
    logic                        roots_valid;

    modport source (
        output valid, output discriminant, output concavity, output root_count,
        output vertex_x, output vertex_y, output root_low, output root_high,
        output roots_valid, input ready
    );
    modport sink (
        input valid, input discriminant, input concavity, input root_count,
        input vertex_x, input vertex_y, input root_low, input root_high,
        input roots_valid, output ready
    );
endinterface

### sv/qea_front.sv
// front end: discriminant products, discriminant and classification
module qea_front #(
    parameter int COEF_BITS = qea_pkg::COEF_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [COEF_BITS-1:0]         coef_a,
    input  logic signed [COEF_BITS-1:0]         coef_b,
    input  logic signed [COEF_BITS-1:0]         coef_c,
    output logic                                out_valid,
    output logic signed [COEF_BITS-1:0]         a_out,
    output logic signed [COEF_BITS-1:0]         b_out,
    output logic signed [2*COEF_BITS+1:0]       d_out,
    output qea_pkg::class_t                     cls_out
);
    localparam int PW = 2 * COEF_BITS;
    localparam int DW = PW + 2;

    logic                        v1_reg;
    logic                        v2_reg;
    logic signed [COEF_BITS-1:0] a1_reg;
    logic signed [COEF_BITS-1:0] b1_reg;
    logic signed [PW-1:0]        bb_reg;
    logic signed [PW-1:0]        ac_reg;
    logic signed [PW-1:0]        bb_next;
    logic signed [PW-1:0]        ac_next;
    logic signed [COEF_BITS-1:0] a2_reg;
    logic signed [COEF_BITS-1:0] b2_reg;
    logic signed [DW-1:0]        d2_reg;
    logic signed [DW-1:0]        d_next;
    qea_pkg::class_t             cls2_reg;
    qea_pkg::class_t             cls_next;

    assign bb_next = coef_b * coef_b;
    assign ac_next = coef_a * coef_c;

    always_comb
    begin
        d_next = $signed({{2{bb_reg[PW-1]}}, bb_reg}) - $signed({ac_reg, 2'b00});
        if (a1_reg == '0)
        begin
            cls_next.concavity = qea_pkg::CONC_FLAT;
        end
        else if (a1_reg[COEF_BITS-1])
        begin
            cls_next.concavity = qea_pkg::CONC_DOWN;
        end
        else
        begin
            cls_next.concavity = qea_pkg::CONC_UP;
        end
        if (d_next[DW-1])
        begin
            cls_next.root_count = qea_pkg::ROOTS_NONE;
        end
        else if (d_next == '0)
        begin
            cls_next.root_count = qea_pkg::ROOTS_ONE;
        end
        else
        begin
            cls_next.root_count = qea_pkg::ROOTS_TWO;
        end
        cls_next.roots_valid = (a1_reg != '0) && !d_next[DW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg   <= coef_a;
            b1_reg   <= coef_b;
            bb_reg   <= bb_next;
            ac_reg   <= ac_next;
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            d2_reg   <= d_next;
            cls2_reg <= cls_next;
        end
    end

    assign out_valid = v2_reg;
    assign a_out     = a2_reg;
    assign b_out     = b2_reg;
    assign d_out     = d2_reg;
    assign cls_out   = cls2_reg;
endmodule

### sv/qea_queue.sv
// short queue between front end and back end
module qea_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = qea_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_next;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> count_reg != '0)
        else $error("queue pop while empty");
endmodule

### sv/qea_sqrt.sv
// pipelined fixed-point square root, one root bit per stage
module qea_sqrt #(
    parameter int DW        = 34,
    parameter int FRAC_BITS = qea_pkg::FRAC_BITS,
    parameter int TW        = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [DW-1:0]                 radicand,
    input  logic [TW-1:0]                 tag_in,
    output logic                          out_valid,
    output logic [(DW+2*FRAC_BITS)/2-1:0] root,
    output logic [TW-1:0]                 tag_out
);
    localparam int RW = DW + 2 * FRAC_BITS;
    localparam int SW = RW / 2;

    logic          v_reg    [1:SW];
    logic [RW-1:0] rad_reg  [1:SW];
    logic [SW:0]   rem_reg  [1:SW];
    logic [SW-1:0] root_reg [1:SW];
    logic [TW-1:0] tag_reg  [1:SW];

    logic          v_src    [0:SW-1];
    logic [RW-1:0] rad_src  [0:SW-1];
    logic [SW:0]   rem_src  [0:SW-1];
    logic [SW-1:0] root_src [0:SW-1];
    logic [TW-1:0] tag_src  [0:SW-1];

    logic [RW-1:0] rad_next  [1:SW];
    logic [SW:0]   rem_next  [1:SW];
    logic [SW-1:0] root_next [1:SW];

    always_comb
    begin
        v_src[0]    = in_valid;
        rad_src[0]  = {radicand, {(2*FRAC_BITS){1'b0}}};
        rem_src[0]  = '0;
        root_src[0] = '0;
        tag_src[0]  = tag_in;
        for (int k = 1; k < SW; k++)
        begin
            v_src[k]    = v_reg[k];
            rad_src[k]  = rad_reg[k];
            rem_src[k]  = rem_reg[k];
            root_src[k] = root_reg[k];
            tag_src[k]  = tag_reg[k];
        end
    end

    // one digit: bring down two radicand bits, try (root*4 + 1)
    always_comb
    begin
        logic [SW+2:0] tmp;
        logic [SW+2:0] trial;
        logic [SW+2:0] diff;
        for (int k = 0; k < SW; k++)
        begin
            tmp   = {rem_src[k], rad_src[k][RW-1:RW-2]};
            trial = {1'b0, root_src[k], 2'b01};
            diff  = tmp - trial;
            rad_next[k+1] = rad_src[k] << 2;
            if (tmp >= trial)
            begin
                rem_next[k+1]  = diff[SW:0];
                root_next[k+1] = {root_src[k][SW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k+1]  = tmp[SW:0];
                root_next[k+1] = {root_src[k][SW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= SW; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 1; k <= SW; k++)
            begin
                v_reg[k] <= v_src[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 1; k <= SW; k++)
            begin
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                tag_reg[k]  <= tag_src[k-1];
            end
        end
    end

    assign out_valid = v_reg[SW];
    assign root      = root_reg[SW];
    assign tag_out   = tag_reg[SW];
endmodule

### sv/qea_div.sv
// pipelined unsigned restoring divider, one quotient bit per stage
module qea_div #(
    parameter int NW  = 50,
    parameter int DVW = 18,
    parameter int TW  = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [NW-1:0]  num,
    input  logic [DVW-1:0] den,
    input  logic [TW-1:0]  tag_in,
    output logic           out_valid,
    output logic [NW-1:0]  quot,
    output logic [TW-1:0]  tag_out
);
    logic           v_reg   [1:NW];
    logic [NW-1:0]  num_reg [1:NW];
    logic [DVW-1:0] den_reg [1:NW];
    logic [DVW-1:0] rem_reg [1:NW];
    logic [NW-1:0]  q_reg   [1:NW];
    logic [TW-1:0]  tag_reg [1:NW];

    logic           v_src   [0:NW-1];
    logic [NW-1:0]  num_src [0:NW-1];
    logic [DVW-1:0] den_src [0:NW-1];
    logic [DVW-1:0] rem_src [0:NW-1];
    logic [NW-1:0]  q_src   [0:NW-1];
    logic [TW-1:0]  tag_src [0:NW-1];

    logic [DVW-1:0] rem_next [1:NW];
    logic [NW-1:0]  q_next   [1:NW];

    always_comb
    begin
        v_src[0]   = in_valid;
        num_src[0] = num;
        den_src[0] = den;
        rem_src[0] = '0;
        q_src[0]   = '0;
        tag_src[0] = tag_in;
        for (int k = 1; k < NW; k++)
        begin
            v_src[k]   = v_reg[k];
            num_src[k] = num_reg[k];
            den_src[k] = den_reg[k];
            rem_src[k] = rem_reg[k];
            q_src[k]   = q_reg[k];
            tag_src[k] = tag_reg[k];
        end
    end

    always_comb
    begin
        logic [DVW:0] tmp;
        logic [DVW:0] diff;
        for (int k = 0; k < NW; k++)
        begin
            tmp  = {rem_src[k], num_src[k][NW-1]};
            diff = tmp - {1'b0, den_src[k]};
            if (tmp >= {1'b0, den_src[k]})
            begin
                rem_next[k+1] = diff[DVW-1:0];
                q_next[k+1]   = {q_src[k][NW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k+1] = tmp[DVW-1:0];
                q_next[k+1]   = {q_src[k][NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= NW; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 1; k <= NW; k++)
            begin
                v_reg[k] <= v_src[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 1; k <= NW; k++)
            begin
                num_reg[k] <= num_src[k-1] << 1;
                den_reg[k] <= den_src[k-1];
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
                tag_reg[k] <= tag_src[k-1];
            end
        end
    end

    assign out_valid = v_reg[NW];
    assign quot      = q_reg[NW];
    assign tag_out   = tag_reg[NW];
endmodule

### sv/quadratic_equation_analyzer.sv
// quadratic analyzer top: front end, queue, square root and divider back end
// path: front-end registers, queue, SW = COEF_BITS + 1 + FRAC_BITS root stages,
//   NW = 2*COEF_BITS + 2 + FRAC_BITS divider stages, then the result register
// one word per cycle unless stalled; the square root and four dividers are fully pipelined
// a stall on the result side freezes the back end; the queue lets the front end run on
// reset clears all valid flags and the queue pointers and count; data registers are not reset
module quadratic_equation_analyzer #(
    parameter int COEF_BITS = qea_pkg::COEF_BITS,
    parameter int FRAC_BITS = qea_pkg::FRAC_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    qea_in_if.sink    req,
    qea_out_if.source rsp
);
    localparam int DW    = 2 * COEF_BITS + 2;
    localparam int SW    = (DW + 2 * FRAC_BITS) / 2;
    localparam int SUMW  = ((COEF_BITS + FRAC_BITS > SW) ? COEF_BITS + FRAC_BITS : SW) + 2;
    localparam int NW    = (DW + FRAC_BITS > SUMW) ? DW + FRAC_BITS : SUMW;
    localparam int DVW   = COEF_BITS + 2;
    localparam int OB    = qea_pkg::OUT_BITS;
    localparam int CLSW  = $bits(qea_pkg::class_t);
    localparam int QW    = 2 * COEF_BITS + DW + CLSW;
    localparam int DTW   = DW + CLSW + 4;

    // front end
    logic                        front_en;
    logic                        front_v;
    logic signed [COEF_BITS-1:0] front_a;
    logic signed [COEF_BITS-1:0] front_b;
    logic signed [DW-1:0]        front_d;
    qea_pkg::class_t             front_cls;

    // queue
    logic          q_push_ready;
    logic          q_valid;
    logic          q_pop;
    logic [QW-1:0] q_data;
    logic signed [COEF_BITS-1:0] q_a;
    logic signed [COEF_BITS-1:0] q_b;
    logic signed [DW-1:0]        q_d;
    qea_pkg::class_t             q_cls;

    // back end
    logic                        back_en;
    logic                        sq_v;
    logic [SW-1:0]               sq_root;
    logic [QW-1:0]               sq_tag;
    logic signed [COEF_BITS-1:0] sa;
    logic signed [COEF_BITS-1:0] sb;
    logic signed [DW-1:0]        sd;
    qea_pkg::class_t             scls;
    logic [COEF_BITS-1:0]        a_mag;
    logic [COEF_BITS-1:0]        b_mag;
    logic [DW-1:0]               d_mag;
    logic signed [SUMW-1:0]      nb;
    logic signed [SUMW-1:0]      s_ext;
    logic signed [SUMW-1:0]      sum_lo;
    logic signed [SUMW-1:0]      sum_hi;
    logic [SUMW-1:0]             lo_mag;
    logic [SUMW-1:0]             hi_mag;
    logic                        neg_vx;
    logic                        neg_vy;
    logic                        neg_lo;
    logic                        neg_hi;
    logic [DTW-1:0]              dv_tag_in;
    logic [DTW-1:0]              dv_tag;
    logic                        dv_v;
    logic [NW-1:0]               q_vx;
    logic [NW-1:0]               q_vy;
    logic [NW-1:0]               q_lo;
    logic [NW-1:0]               q_hi;
    logic signed [DW-1:0]        o_d;
    qea_pkg::class_t             o_cls;
    logic                        o_neg_vx;
    logic                        o_neg_vy;
    logic                        o_neg_lo;
    logic                        o_neg_hi;
    logic [OB-1:0]               m_vx;
    logic [OB-1:0]               m_vy;
    logic [OB-1:0]               m_lo;
    logic [OB-1:0]               m_hi;

    // result register
    logic                 out_v_reg;
    logic signed [DW-1:0] disc_reg;
    qea_pkg::class_t      cls_reg;
    logic signed [OB-1:0] vx_reg;
    logic signed [OB-1:0] vy_reg;
    logic signed [OB-1:0] lo_reg;
    logic signed [OB-1:0] hi_reg;
    logic signed [OB-1:0] vx_next;
    logic signed [OB-1:0] vy_next;
    logic signed [OB-1:0] lo_next;
    logic signed [OB-1:0] hi_next;

    assign front_en  = !front_v || q_push_ready;
    assign req.ready = front_en;

    qea_front #(
        .COEF_BITS (COEF_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (front_en),
        .in_valid  (req.valid),
        .coef_a    (req.coef_a),
        .coef_b    (req.coef_b),
        .coef_c    (req.coef_c),
        .out_valid (front_v),
        .a_out     (front_a),
        .b_out     (front_b),
        .d_out     (front_d),
        .cls_out   (front_cls)
    );

    qea_queue #(
        .WIDTH (QW),
        .DEPTH (qea_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_v && front_en),
        .push_data  ({front_a, front_b, front_d, front_cls}),
        .push_ready (q_push_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_data)
    );

    assign back_en = !out_v_reg || rsp.ready;
    assign q_pop   = back_en && q_valid;
    assign {q_a, q_b, q_d, q_cls} = q_data;

    qea_sqrt #(
        .DW        (DW),
        .FRAC_BITS (FRAC_BITS),
        .TW        (QW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .in_valid  (q_valid),
        .radicand  (q_d[DW-1] ? '0 : q_d),
        .tag_in    (q_data),
        .out_valid (sq_v),
        .root      (sq_root),
        .tag_out   (sq_tag)
    );

    assign {sa, sb, sd, scls} = sq_tag;

    // operand magnitudes and quotient signs for the dividers
    always_comb
    begin
        a_mag  = sa[COEF_BITS-1] ? COEF_BITS'(-sa) : COEF_BITS'(sa);
        b_mag  = sb[COEF_BITS-1] ? COEF_BITS'(-sb) : COEF_BITS'(sb);
        d_mag  = sd[DW-1] ? DW'(-sd) : DW'(sd);
        nb     = -(SUMW'(sb) <<< FRAC_BITS);
        s_ext  = $signed(SUMW'(sq_root));
        sum_lo = nb - s_ext;
        sum_hi = nb + s_ext;
        lo_mag = sum_lo[SUMW-1] ? SUMW'(-sum_lo) : SUMW'(sum_lo);
        hi_mag = sum_hi[SUMW-1] ? SUMW'(-sum_hi) : SUMW'(sum_hi);
        neg_vx = (!sb[COEF_BITS-1] && sb != '0) ^ sa[COEF_BITS-1];
        neg_vy = (!sd[DW-1] && sd != '0) ^ sa[COEF_BITS-1];
        neg_lo = sum_lo[SUMW-1] ^ sa[COEF_BITS-1];
        neg_hi = sum_hi[SUMW-1] ^ sa[COEF_BITS-1];
    end

    assign dv_tag_in = {sd, scls, neg_vx, neg_vy, neg_lo, neg_hi};

    qea_div #(
        .NW  (NW),
        .DVW (DVW),
        .TW  (DTW)
    ) u_div_vx (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .in_valid  (sq_v),
        .num       (NW'({b_mag, {FRAC_BITS{1'b0}}})),
        .den       (DVW'({a_mag, 1'b0})),
        .tag_in    (dv_tag_in),
        .out_valid (dv_v),
        .quot      (q_vx),
        .tag_out   (dv_tag)
    );

    qea_div #(
        .NW  (NW),
        .DVW (DVW),
        .TW  (1)
    ) u_div_vy (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .in_valid  (sq_v),
        .num       (NW'({d_mag, {FRAC_BITS{1'b0}}})),
        .den       (DVW'({a_mag, 2'b00})),
        .tag_in    (1'b0),
        .out_valid (),
        .quot      (q_vy),
        .tag_out   ()
    );

    qea_div #(
        .NW  (NW),
        .DVW (DVW),
        .TW  (1)
    ) u_div_lo (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .in_valid  (sq_v),
        .num       (NW'(lo_mag)),
        .den       (DVW'({a_mag, 1'b0})),
        .tag_in    (1'b0),
        .out_valid (),
        .quot      (q_lo),
        .tag_out   ()
    );

    qea_div #(
        .NW  (NW),
        .DVW (DVW),
        .TW  (1)
    ) u_div_hi (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .in_valid  (sq_v),
        .num       (NW'(hi_mag)),
        .den       (DVW'({a_mag, 1'b0})),
        .tag_in    (1'b0),
        .out_valid (),
        .quot      (q_hi),
        .tag_out   ()
    );

    assign {o_d, o_cls, o_neg_vx, o_neg_vy, o_neg_lo, o_neg_hi} = dv_tag;

    // apply signs; vertex needs a nonzero a, roots need a real solution
    always_comb
    begin
        m_vx    = OB'(q_vx);
        m_vy    = OB'(q_vy);
        m_lo    = OB'(q_lo);
        m_hi    = OB'(q_hi);
        vx_next = '0;
        vy_next = '0;
        lo_next = '0;
        hi_next = '0;
        if (o_cls.concavity != qea_pkg::CONC_FLAT)
        begin
            vx_next = o_neg_vx ? $signed(-m_vx) : $signed(m_vx);
            vy_next = o_neg_vy ? $signed(-m_vy) : $signed(m_vy);
        end
        if (o_cls.roots_valid)
        begin
            lo_next = o_neg_lo ? $signed(-m_lo) : $signed(m_lo);
            hi_next = o_neg_hi ? $signed(-m_hi) : $signed(m_hi);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (back_en)
        begin
            out_v_reg <= dv_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            disc_reg <= o_d;
            cls_reg  <= o_cls;
            vx_reg   <= vx_next;
            vy_reg   <= vy_next;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
        end
    end

    assign rsp.valid        = out_v_reg;
    assign rsp.discriminant = disc_reg;
    assign rsp.concavity    = cls_reg.concavity;
    assign rsp.root_count   = cls_reg.root_count;
    assign rsp.vertex_x     = vx_reg;
    assign rsp.vertex_y     = vy_reg;
    assign rsp.root_low     = lo_reg;
    assign rsp.root_high    = hi_reg;
    assign rsp.roots_valid  = cls_reg.roots_valid;

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.roots_valid |-> rsp.concavity != qea_pkg::CONC_FLAT)
        else $error("roots flagged valid for a flat curve");
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.roots_valid |-> rsp.root_count != qea_pkg::ROOTS_NONE)
        else $error("roots flagged valid with negative discriminant");
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.concavity == qea_pkg::CONC_FLAT |->
            rsp.vertex_x == '0 && rsp.vertex_y == '0)
        else $error("vertex nonzero for a flat curve");
endmodule

### tb/qea_checker.sv
// checker for the quadratic analyzer: predicts each result word and compares it
`timescale 1ns / 100ps
module qea_checker (
    input  logic      clk,
    input  logic      rst_n,
    qea_in_if.sink    req_mon,
    qea_out_if.sink   rsp_mon,
    output int        fail_count,
    output int        pending,
    output int        checked
);

    typedef struct {
        logic signed [33:0] disc;
        qea_pkg::conc_t     conc;
        qea_pkg::count_t    cnt;
        logic signed [63:0] vx;
        logic signed [63:0] vy;
        logic signed [63:0] rl;
        logic signed [63:0] rh;
        logic               valid;
    } analysis_t;

    analysis_t expected_q[$];

    // trunc(num * 2^sh / den) toward zero, modulo 2^64
    function automatic logic [63:0] fixed_quot(input longint num, input longint den,
                                               input int sh);
        logic [63:0] n, d, q, r, m;
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = n / d;
        r = n % d;
        m = (q << sh) + ((r << sh) / d);
        return ((num < 0) != (den < 0)) ? -m : m;
    endfunction

    // floor(sqrt(v) * 2^FRAC_BITS), bit by bit
    function automatic logic [63:0] fixed_sqrt(input logic [63:0] v);
        logic [63:0] s, rem, bit_w, r4, t;
        s = 0;
        rem = v;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
            bit_w = bit_w >> 2;
        while (bit_w != 0)
        begin
            if (rem >= s + bit_w)
            begin
                rem = rem - (s + bit_w);
                s = (s >> 1) + bit_w;
            end
            else
                s = s >> 1;
            bit_w = bit_w >> 2;
        end
        for (int k = 0; k < qea_pkg::FRAC_BITS; k++)
        begin
            r4 = rem << 2;
            t = (s << 2) + 1;
            if (r4 >= t)
            begin
                rem = r4 - t;
                s = (s << 1) + 1;
            end
            else
            begin
                rem = r4;
                s = s << 1;
            end
        end
        return s;
    endfunction

    function automatic analysis_t analyze(input longint a, input longint b, input longint c);
        analysis_t e;
        longint d, s, nb;
        d = b * b - 4 * a * c;
        e.disc = d[33:0];
        e.conc = a > 0 ? qea_pkg::CONC_UP : (a < 0 ? qea_pkg::CONC_DOWN : qea_pkg::CONC_FLAT);
        e.cnt = d > 0 ? qea_pkg::ROOTS_TWO : (d == 0 ? qea_pkg::ROOTS_ONE : qea_pkg::ROOTS_NONE);
        e.vx = 0;
        e.vy = 0;
        e.rl = 0;
        e.rh = 0;
        e.valid = 0;
        if (a != 0)
        begin
            e.vx = fixed_quot(-b, 2 * a, qea_pkg::FRAC_BITS);
            e.vy = fixed_quot(-d, 4 * a, qea_pkg::FRAC_BITS);
            if (d >= 0)
            begin
                s = fixed_sqrt(d);
                nb = -b * (64'sd1 <<< qea_pkg::FRAC_BITS);
                e.rl = fixed_quot(nb - s, 2 * a, 0);
                e.rh = fixed_quot(nb + s, 2 * a, 0);
                e.valid = 1;
            end
        end
        return e;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        analysis_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
            checked <= 0;
            pending <= 0;
        end
        else
        begin
            if (req_mon.valid && req_mon.ready)
                expected_q.push_back(analyze(req_mon.coef_a, req_mon.coef_b, req_mon.coef_c));
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                checked <= checked + 1;
                if (expected_q.size() == 0)
                begin
                    $error("result word with no coefficient set waiting");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (rsp_mon.discriminant !== e.disc ||
                        rsp_mon.concavity !== e.conc ||
                        rsp_mon.root_count !== e.cnt ||
                        rsp_mon.vertex_x !== e.vx || rsp_mon.vertex_y !== e.vy ||
                        rsp_mon.root_low !== e.rl || rsp_mon.root_high !== e.rh ||
                        rsp_mon.roots_valid !== e.valid)
                        fail_count <= fail_count + 1;
                    if (rsp_mon.discriminant !== e.disc)
                        $error("discriminant: expected %0d, got %0d", e.disc,
                               rsp_mon.discriminant);
                    if (rsp_mon.concavity !== e.conc)
                        $error("concavity: expected %0d, got %0d", e.conc, rsp_mon.concavity);
                    if (rsp_mon.root_count !== e.cnt)
                        $error("root_count: expected %0d, got %0d", e.cnt, rsp_mon.root_count);
                    if (rsp_mon.vertex_x !== e.vx)
                        $error("vertex_x: expected %0d, got %0d", e.vx, rsp_mon.vertex_x);
                    if (rsp_mon.vertex_y !== e.vy)
                        $error("vertex_y: expected %0d, got %0d", e.vy, rsp_mon.vertex_y);
                    if (rsp_mon.root_low !== e.rl)
                        $error("root_low: expected %0d, got %0d", e.rl, rsp_mon.root_low);
                    if (rsp_mon.root_high !== e.rh)
                        $error("root_high: expected %0d, got %0d", e.rh, rsp_mon.root_high);
                    if (rsp_mon.roots_valid !== e.valid)
                        $error("roots_valid: expected %0d, got %0d", e.valid,
                               rsp_mon.roots_valid);
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

### tb/tb_quadratic_equation_analyzer.sv
// testbench top for the quadratic analyzer: stimulus, back pressure and verdict
`timescale 1ns / 100ps
module tb_quadratic_equation_analyzer;

    localparam int RANDOM_SETS = 530;
    localparam int DRAIN_CYCLES = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   checked;
    int   sent = 0;
    bit   no_idle_out = 0;

    qea_in_if  req ();
    qea_out_if rsp ();

    quadratic_equation_analyzer i_dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));
    qea_checker i_checker (.clk(clk), .rst_n(rst_n), .req_mon(req), .rsp_mon(rsp),
                           .fail_count(fail_count), .pending(pending), .checked(checked));

    always #6 clk = ~clk;

    // result side stalls with a chance of about one in five, except during the quiet stretch
    always @(posedge clk)
        rsp.ready <= no_idle_out || ($urandom_range(99) >= 20);

    task automatic send_word(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c,
                             input bit may_idle);
        while (may_idle && $urandom_range(99) < 20)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.coef_a <= a;
        req.coef_b <= b;
        req.coef_c <= c;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sent++;
    endtask

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(5))
            0: return 16'(16'h8000 + $urandom_range(3));
            1: return 16'(16'h7fff - $urandom_range(3));
            2: return 16'($urandom_range(8) - 4);
            3: return 16'($urandom_range(400) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] a, b, c;
        logic [15:0] edges[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff};
        req.valid = 1'b0;
        req.coef_a = '0;
        req.coef_b = '0;
        req.coef_c = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes, flat, double root, no real roots, negative a
        send_word(16'h8000, 16'h8000, 16'h7fff, 0);
        send_word(16'h8000, 16'h7fff, 16'h7fff, 0);
        send_word(16'h7fff, 16'h8000, 16'h8000, 0);
        send_word(16'h7fff, 16'h7fff, 16'h7fff, 0);
        send_word(16'h0000, 16'h0005, 16'h0003, 0);
        send_word(16'h0000, 16'h0000, 16'h0000, 0);
        send_word(16'h0001, 16'hfffe, 16'h0001, 0);
        send_word(16'h0001, 16'h0000, 16'h0001, 0);
        send_word(16'hffff, 16'h0003, 16'h0004, 0);
        send_word(16'h0003, 16'h0007, 16'h0002, 0);
        send_word(16'hfffd, 16'hfff9, 16'hfffe, 0);
        send_word(16'hffff, 16'hffff, 16'hffff, 0);
        for (int i = 0; i < 10; i++)
            send_word(edges[$urandom_range(4)], edges[$urandom_range(4)],
                      edges[$urandom_range(4)], 0);
        for (int i = 0; i < RANDOM_SETS; i++)
        begin
            if (i == 200)
            begin
                // hold off until the pipeline has drained
                req.valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            no_idle_out = (i >= 300 && i < 380);
            a = rand_coef();
            b = rand_coef();
            c = rand_coef();
            if ($urandom_range(9) == 0)
                c = (b * b) / 4;
            send_word(a, b, c, !no_idle_out);
        end
        req.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d coefficient sets, checked %0d result words", sent, checked);
        $display("covered extremes, flat and double-root cases, random stalls and a drain");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
sv/qea_pkg.sv
sv/qea_in_if.sv
sv/qea_out_if.sv
sv/qea_front.sv
sv/qea_queue.sv
sv/qea_sqrt.sv
sv/qea_div.sv
sv/quadratic_equation_analyzer.sv
tb/qea_checker.sv
tb/tb_quadratic_equation_analyzer.sv
